@@ src/chained_hash_map_engine_assert.svh @@
`ifndef CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CHME_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chained hash map check failed");

// next-cycle implication, disabled while reset is asserted
`define CHME_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chained hash map check failed");

`endif

@@ src/chme_pkg.sv @@
package chme_pkg;

	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int CFG_W     = 8;

	// remainder unit: bits of the key retired per cycle
	localparam int DIGIT_W   = 4;
	localparam int MOD_STEPS = KEY_W / DIGIT_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam logic [CFG_W-1:0] DEFAULT_BUCKETS = 8'd127;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_POOL_FULL = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} chme_req_t;

	typedef struct packed {
		logic             status;
		logic             found;
		logic [VAL_W-1:0] read_value;
	} chme_rsp_t;

endpackage

@@ src/chained_hash_map_engine.sv @@
// Key-to-value map held as a separately chained hash table. A request is an
// insert (replacing the value of a key already present) or a lookup; each
// gives exactly one response. The bucket is key mod bucket_count (zero
// means 127, larger values are capped at MAX_BUCKETS), worked out four key
// bits a cycle; the node RAM is read once a cycle while the chain is walked.
// New keys take the next node of the pool and go to the head of their
// chain; a full pool fails the insert. Changing bucket_count does not
// rehash. After reset the bucket head RAM is cleared, one bucket a cycle;
// requests are stalled meanwhile. A response may wait in the output
// register while the next request is taken.
module chained_hash_map_engine #(
	parameter int MAX_BUCKETS = 128,
	parameter int POOL_NODES  = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  chme_pkg::chme_req_t        req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output chme_pkg::chme_rsp_t        rsp_data,
	input  logic                        cfg_we,
	input  logic [chme_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int BW     = $clog2(MAX_BUCKETS);
	localparam int NW     = $clog2(POOL_NODES);
	localparam int LW     = $clog2(POOL_NODES + 1);
	localparam int NODE_W = LW + chme_pkg::KEY_W + chme_pkg::VAL_W;
	localparam logic [LW-1:0] EMPTY_LINK = LW'(POOL_NODES);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_HEAD,
		S_NODE,
		S_DONE
	} state_t;

	state_t                     state_q;
	chme_pkg::chme_req_t       req_q;
	chme_pkg::chme_rsp_t       res_q;
	chme_pkg::chme_rsp_t       rsp_q;
	logic                       rsp_valid_q;
	logic [chme_pkg::CFG_W-1:0] bucket_count_q;
	logic [BW-1:0]              bucket_q;
	logic [BW-1:0]              clr_q;
	logic [LW-1:0]              head_q;
	logic [LW-1:0]              cur_q;
	logic [LW-1:0]              used_q;

	logic [chme_pkg::CFG_W-1:0] eff_buckets;
	logic                       req_acc;
	logic                       mod_done;
	logic [chme_pkg::CFG_W-1:0] mod_rem;
	logic [BW-1:0]              mod_bucket;

	logic                       head_we;
	logic [BW-1:0]              head_waddr;
	logic [LW-1:0]              head_wdata;
	logic [LW-1:0]              head_rdata;

	logic                       node_we;
	logic [NW-1:0]              node_waddr;
	logic [NODE_W-1:0]          node_wdata;
	logic [NW-1:0]              node_raddr;
	logic [NODE_W-1:0]          node_rdata;

	logic [LW-1:0]              node_next_rd;
	logic [chme_pkg::KEY_W-1:0] node_key_rd;
	logic [chme_pkg::VAL_W-1:0] node_val_rd;
	logic [LW-1:0]              head_link;
	logic                       key_hit;
	logic                       miss;
	logic                       pool_full;
	logic                       ins_new;
	logic                       replace;
	chme_pkg::chme_rsp_t       res_next;

	always_comb begin
		eff_buckets = bucket_count_q;
		if (bucket_count_q == '0) begin
			eff_buckets = chme_pkg::DEFAULT_BUCKETS;
		end
		if (32'(eff_buckets) > MAX_BUCKETS) begin
			eff_buckets = chme_pkg::CFG_W'(MAX_BUCKETS);
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;

	chme_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (req_acc),
		.key     (req_data.key),
		.divisor (eff_buckets),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// remainder is below the bucket count, so it fits the bucket index
	assign mod_bucket = BW'(mod_rem);

	assign {node_next_rd, node_key_rd, node_val_rd} = node_rdata;

	always_comb begin
		head_link = (state_q == S_HEAD) ? head_rdata : head_q;
		pool_full = (used_q == LW'(POOL_NODES));
		key_hit   = (state_q == S_NODE) && (node_key_rd == req_q.key);
		miss      = ((state_q == S_HEAD) && (head_rdata >= used_q)) ||
		            ((state_q == S_NODE) && !key_hit && (node_next_rd >= used_q));
		ins_new   = miss && (req_q.req_type == chme_pkg::REQ_INSERT) && !pool_full;
		replace   = key_hit && (req_q.req_type == chme_pkg::REQ_INSERT);

		node_raddr = (state_q == S_HEAD) ? head_rdata[NW-1:0] : node_next_rd[NW-1:0];
		node_we    = ins_new || replace;
		node_waddr = replace ? cur_q[NW-1:0] : used_q[NW-1:0];
		node_wdata = replace ? {node_next_rd, req_q.key, req_q.value}
		                     : {head_link, req_q.key, req_q.value};

		head_we    = (state_q == S_CLEAR) || ins_new;
		head_waddr = (state_q == S_CLEAR) ? clr_q : bucket_q;
		head_wdata = (state_q == S_CLEAR) ? EMPTY_LINK : used_q;

		res_next            = '0;
		res_next.status     = chme_pkg::STATUS_OK;
		if (key_hit) begin
			res_next.found = 1'b1;
			if (req_q.req_type == chme_pkg::REQ_LOOKUP) begin
				res_next.read_value = node_val_rd;
			end
		end else if (miss && (req_q.req_type == chme_pkg::REQ_INSERT) && pool_full) begin
			res_next.status = chme_pkg::STATUS_POOL_FULL;
		end
	end

	chme_ram #(
		.DEPTH (MAX_BUCKETS),
		.WIDTH (LW)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (mod_bucket),
		.rdata (head_rdata)
	);

	chme_ram #(
		.DEPTH (POOL_NODES),
		.WIDTH (NODE_W)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			used_q         <= '0;
			rsp_valid_q    <= 1'b0;
			bucket_count_q <= chme_pkg::DEFAULT_BUCKETS;
		end else begin
			if (cfg_we) begin
				bucket_count_q <= cfg_wdata;
			end
			if ((state_q == S_DONE) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (ins_new) begin
				used_q <= used_q + 1'b1;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(MAX_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						req_q   <= req_data;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						bucket_q <= mod_bucket;
						state_q  <= S_HEAD;
					end
				end
				S_HEAD: begin
					head_q <= head_rdata;
					cur_q  <= head_rdata;
					if (miss) begin
						res_q   <= res_next;
						state_q <= S_DONE;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					cur_q <= node_next_rd;
					if (key_hit || miss) begin
						res_q   <= res_next;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

@@ src/chme_ram.sv @@
module chme_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/chme_mod_unit.sv @@
module chme_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [chme_pkg::KEY_W-1:0] key,
	input  logic [chme_pkg::CFG_W-1:0] divisor,
	output logic                        done,
	output logic [chme_pkg::CFG_W-1:0] rem
);

	logic                            busy_q;
	logic                            done_q;
	logic [chme_pkg::MOD_CNT_W-1:0] cnt_q;
	logic [chme_pkg::KEY_W-1:0]     key_q;
	logic [chme_pkg::CFG_W-1:0]     div_q;
	logic [chme_pkg::CFG_W-1:0]     rem_q;
	logic [chme_pkg::CFG_W-1:0]     rem_next;

	// restoring remainder, one digit per cycle; partial stays below twice the divisor
	always_comb begin
		logic [chme_pkg::CFG_W:0] part;
		part = {1'b0, rem_q};
		for (int i = 0; i < chme_pkg::DIGIT_W; i++) begin
			part = {part[chme_pkg::CFG_W-1:0], key_q[chme_pkg::KEY_W-1-i]};
			if (part >= {1'b0, div_q}) begin
				part = part - {1'b0, div_q};
			end
		end
		rem_next = part[chme_pkg::CFG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == chme_pkg::MOD_CNT_W'(chme_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			key_q <= key_q << chme_pkg::DIGIT_W;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ src/chme_checker.sv @@
`include "chained_hash_map_engine_assert.svh"

module chme_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_stall,
	input logic                  rsp_valid,
	input logic                  rsp_stall,
	input chme_pkg::chme_rsp_t  rsp_data
);

	// a held response stays offered
	`CHME_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

	// one request at a time: an accepted request closes the input
	`CHME_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

	// a failed insert neither finds nor returns anything
	`CHME_ASSERT_NOW(a_fail_clean, rsp_valid && rsp_data.status,
		!rsp_data.found && (rsp_data.read_value == '0))

	// a miss returns zero
	`CHME_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_data.found, rsp_data.read_value == '0)

endmodule

bind chained_hash_map_engine chme_checker u_chme_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

@@ verif/chained_hash_map_engine_tb.sv @@
module chained_hash_map_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_BUCKETS    = 128;
	localparam int MAP_NODES      = 256;
	localparam int RANDOM_ITEMS   = 1900;
	localparam int TRAFFIC_PHASES = 10;
	localparam int DRAIN_CYCLES   = 300;
	localparam int LIMIT_CYCLES   = 4_000_000;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_stall;
	chme_pkg::chme_req_t        req_data  = '0;
	logic                       rsp_valid;
	logic                       rsp_stall = 1'b0;
	chme_pkg::chme_rsp_t        rsp_data;
	logic                       cfg_we    = 1'b0;
	logic [chme_pkg::CFG_W-1:0] cfg_wdata = '0;

	chained_hash_map_engine #(
		.MAX_BUCKETS(MAP_BUCKETS),
		.POOL_NODES (MAP_NODES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// shadow copy of the table
	int unsigned                chain_head  [MAP_BUCKETS];
	int unsigned                chain_next  [MAP_NODES];
	logic [chme_pkg::KEY_W-1:0] node_key_of [MAP_NODES];
	logic [chme_pkg::VAL_W-1:0] node_val_of [MAP_NODES];
	int unsigned                nodes_taken;
	logic [chme_pkg::CFG_W-1:0] bucket_setting;
	logic [chme_pkg::KEY_W-1:0] stored_keys [$];
	chme_pkg::chme_rsp_t        owed_responses [$];

	int                  cycles = 0;
	int                  errors = 0;
	int                  n_requests = 0;
	int                  n_checked = 0;
	int                  n_hits = 0;
	int                  n_rejects = 0;
	int                  n_settings = 0;
	int                  stall_left = 0;
	bit                  no_idle = 1'b0;
	chme_pkg::chme_rsp_t want;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		while (cycles < LIMIT_CYCLES) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 17);
	endfunction

	// walks the selected chain and applies the request to the shadow table
	function automatic chme_pkg::chme_rsp_t map_response(input chme_pkg::chme_req_t r);
		int unsigned         buckets, slot, cur, steps, hit;
		chme_pkg::chme_rsp_t rsp;
		buckets = bucket_setting;
		if (buckets == 0) buckets = chme_pkg::DEFAULT_BUCKETS;
		if (buckets > MAP_BUCKETS) buckets = MAP_BUCKETS;
		slot  = r.key % buckets;
		hit   = MAP_NODES;
		cur   = chain_head[slot];
		steps = 0;
		while (hit == MAP_NODES && cur < nodes_taken && steps <= nodes_taken) begin
			if (node_key_of[cur] == r.key) begin
				hit = cur;
			end else begin
				cur = chain_next[cur];
				steps++;
			end
		end
		rsp = '0;
		rsp.status = chme_pkg::STATUS_OK;
		if (r.req_type == chme_pkg::REQ_LOOKUP) begin
			if (hit != MAP_NODES) begin
				rsp.found = 1'b1;
				rsp.read_value = node_val_of[hit];
			end
		end else if (hit != MAP_NODES) begin
			node_val_of[hit] = r.value;
			rsp.found = 1'b1;
		end else if (nodes_taken >= MAP_NODES) begin
			rsp.status = chme_pkg::STATUS_POOL_FULL;
		end else begin
			// new node goes to the head of its chain
			chain_next[nodes_taken]  = chain_head[slot];
			node_key_of[nodes_taken] = r.key;
			node_val_of[nodes_taken] = r.value;
			chain_head[slot] = nodes_taken;
			nodes_taken++;
			stored_keys.push_back(r.key);
		end
		return rsp;
	endfunction

	function automatic logic [chme_pkg::KEY_W-1:0] fresh_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1023);
			1: return 32'hFFFF_FC00 | $urandom_range(0, 1023);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [chme_pkg::KEY_W-1:0] pick_known();
		return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
	endfunction

	function automatic logic [chme_pkg::VAL_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// valid is left high on return so a back-to-back request needs no drop
	task automatic send_request(input logic kind, input logic [chme_pkg::KEY_W-1:0] key,
			input logic [chme_pkg::VAL_W-1:0] value);
		int                  gap;
		chme_pkg::chme_req_t r;
		chme_pkg::chme_rsp_t rsp;
		gap = draw_wait();
		r.req_type = kind;
		r.key      = key;
		r.value    = value;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		rsp = map_response(r);
		owed_responses.push_back(rsp);
		n_requests++;
		if (rsp.status == chme_pkg::STATUS_POOL_FULL) n_rejects++;
		if (kind == chme_pkg::REQ_LOOKUP && rsp.found) n_hits++;
	endtask

	task automatic settle_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (owed_responses.size() != 0);
	endtask

	task automatic set_bucket_count(input logic [chme_pkg::CFG_W-1:0] count);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		bucket_setting = count;
		n_settings++;
		@(posedge clk);
	endtask

	// response side: random stall, compare against the oldest owed response
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			n_checked++;
			if (owed_responses.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				want = owed_responses.pop_front();
				if (rsp_data.status !== want.status) begin
					$error("field status expected %0d actual %0d", want.status, rsp_data.status);
					errors++;
				end
				if (rsp_data.found !== want.found) begin
					$error("field found expected %0d actual %0d", want.found, rsp_data.found);
					errors++;
				end
				if (rsp_data.read_value !== want.read_value) begin
					$error("field read_value expected %h actual %h",
						want.read_value, rsp_data.read_value);
					errors++;
				end
			end
			stall_left = draw_wait();
		end else if (stall_left > 0) begin
			stall_left--;
		end
		rsp_stall <= (stall_left != 0);
	end

	// default count of 127: keys 0, 127, 254 share bucket 0
	task automatic test_empty_and_chained();
		send_request(chme_pkg::REQ_LOOKUP, 32'd0, 32'd0);
		send_request(chme_pkg::REQ_INSERT, 32'd0, 32'hFFFF_FFFF);
		send_request(chme_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'd0);
		send_request(chme_pkg::REQ_INSERT, 32'd127, 32'h1234_5678);
		send_request(chme_pkg::REQ_INSERT, 32'd254, 32'h0BAD_F00D);
		send_request(chme_pkg::REQ_LOOKUP, 32'd0, 32'd0);
		send_request(chme_pkg::REQ_LOOKUP, 32'd127, 32'd0);
		send_request(chme_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'd0);
		send_request(chme_pkg::REQ_INSERT, 32'd0, 32'hA5A5_A5A5);
		send_request(chme_pkg::REQ_LOOKUP, 32'd0, 32'hFFFF_FFFF);
		send_request(chme_pkg::REQ_LOOKUP, 32'd381, 32'd0);
		send_request(chme_pkg::REQ_LOOKUP, 32'd126, 32'd0);
	endtask

	// zero, saturation and no rehash on a change of count
	task automatic test_bucket_count_changes();
		settle_idle();
		set_bucket_count(8'd0);
		send_request(chme_pkg::REQ_LOOKUP, 32'd254, 32'd0);
		send_request(chme_pkg::REQ_INSERT, 32'd381, 32'd1);
		settle_idle();
		set_bucket_count(8'd200);
		send_request(chme_pkg::REQ_LOOKUP, 32'd127, 32'd0);
		send_request(chme_pkg::REQ_INSERT, 32'd127, 32'd2);
		send_request(chme_pkg::REQ_LOOKUP, 32'd127, 32'd0);
		settle_idle();
		set_bucket_count(8'd255);
		send_request(chme_pkg::REQ_LOOKUP, 32'd256, 32'd0);
		send_request(chme_pkg::REQ_LOOKUP, 32'd254, 32'd0);
		settle_idle();
		set_bucket_count(8'd1);
		send_request(chme_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'd0);
		send_request(chme_pkg::REQ_INSERT, 32'd5, 32'd3);
		send_request(chme_pkg::REQ_LOOKUP, 32'd0, 32'd0);
	endtask

	// mostly traffic on keys already stored, some fresh keys and misses
	task automatic test_random_traffic();
		logic [chme_pkg::CFG_W-1:0] settings [TRAFFIC_PHASES];
		int                         roll;
		settings = '{8'd127, 8'd1, 8'd2, 8'd128, 8'd0, 8'd255, 8'd3, 8'd64, 8'd129, 8'd7};
		settings[6] = 8'($urandom_range(3, 126));
		settings[9] = 8'($urandom_range(1, 255));
		for (int p = 0; p < TRAFFIC_PHASES; p++) begin
			settle_idle();
			set_bucket_count(settings[p]);
			no_idle = (p % 3 == 1);
			for (int i = 0; i < RANDOM_ITEMS / TRAFFIC_PHASES; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 40)
					send_request(chme_pkg::REQ_LOOKUP, pick_known(), random_value());
				else if (roll < 60)
					send_request(chme_pkg::REQ_INSERT, pick_known(), random_value());
				else if (roll < 85)
					send_request(chme_pkg::REQ_INSERT, fresh_key(), random_value());
				else
					send_request(chme_pkg::REQ_LOOKUP, fresh_key(), random_value());
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic test_pool_exhaustion();
		int guard;
		settle_idle();
		set_bucket_count(8'd16);
		guard = 0;
		while (nodes_taken < MAP_NODES && guard < 1000) begin
			send_request(chme_pkg::REQ_INSERT, fresh_key(), random_value());
			guard++;
		end
		repeat (6) send_request(chme_pkg::REQ_INSERT, fresh_key(), random_value());
		repeat (4) send_request(chme_pkg::REQ_INSERT, pick_known(), random_value());
		repeat (4) send_request(chme_pkg::REQ_LOOKUP, pick_known(), random_value());
	endtask

	initial begin
		for (int b = 0; b < MAP_BUCKETS; b++) chain_head[b] = MAP_NODES;
		nodes_taken    = 0;
		bucket_setting = chme_pkg::DEFAULT_BUCKETS;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_and_chained();
		test_bucket_count_changes();
		test_random_traffic();
		test_pool_exhaustion();

		settle_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d lookup hits, %0d rejected on a full pool",
			n_requests, n_hits, n_rejects);
		$display("%0d responses checked over %0d bucket count settings, %0d nodes used",
			n_checked, n_settings, nodes_taken);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
